>>> rtl/vfdpw_pkg.sv
// Shared types, constants and address helpers for the VFD pixel frame writer.
package vfdpw_pkg;

  // Input stream layout, first field in the lowest bits.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  // Opcode carried in the op field.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  // Byte index math runs at this width; every in-range pixel lands below 1024.
  localparam int unsigned CALC_W = 11;

  // Above these base indexes the panel layout skips a gap of bytes.
  localparam logic [CALC_W-1:0] BASE_HI_LIMIT = 11'd480;
  localparam logic [CALC_W-1:0] BASE_LO_LIMIT = 11'd256;
  localparam logic [CALC_W-1:0] GAP_HI        = 11'd32;
  localparam logic [CALC_W-1:0] GAP_LO        = 11'd16;

  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_DROP = 2'd1,
    KIND_READ = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] bit_idx;
    logic       pixel_on;
  } cmd_t;

  // Bit inside the 3-bit field for a column; odd and even groups are wired differently.
  function automatic logic [1:0] field_bit(input logic odd, input logic [1:0] col);
    logic [1:0] b;
    case (col)
      2'd0:    b = 2'd1;
      2'd1:    b = odd ? 2'd2 : 2'd0;
      2'd2:    b = odd ? 2'd0 : 2'd2;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/vfdpw_front.sv
// Front end: classifies an item and turns a pixel into a byte address and bit.
module vfdpw_front #(
  parameter int unsigned WIDTH  = 144,
  parameter int unsigned HEIGHT = 20,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                 op_i,
  input  logic [7:0]           pixel_x_i,
  input  logic [4:0]           pixel_y_i,
  input  logic                 pixel_on_i,
  input  logic [9:0]           read_address_i,
  output vfdpw_pkg::cmd_t      cmd_o,
  output logic [ADDR_W-1:0]    addr_o
);
  import vfdpw_pkg::*;

  logic [15:0]       grp_prod;
  logic [6:0]        grp;
  logic [7:0]        col_full;
  logic [1:0]        col;
  logic [4:0]        row;
  logic [2:0]        row_q4;
  logic [1:0]        row_r4;
  logic              odd;
  logic [CALC_W-1:0] base_raw;
  logic [CALC_W-1:0] base_adj;
  logic [4:0]        start;
  logic [4:0]        pos;
  logic [CALC_W-1:0] byte_idx;
  logic              in_range;

  always_comb begin
    // x/3 by reciprocal: exact for every 8-bit x.
    grp_prod = 16'(pixel_x_i) * 16'd171;
    grp      = grp_prod[15:9];
    col_full = pixel_x_i - 8'({grp, 1'b0}) - 8'(grp);
    col      = col_full[1:0];
    odd      = grp[0];

    row    = 5'(HEIGHT - 1) - pixel_y_i;
    row_q4 = row[4:2];
    row_r4 = row[1:0];

    base_raw = CALC_W'(2) + CALC_W'({grp, 4'b0000}) + CALC_W'(row_q4)
             + CALC_W'({row_q4, 1'b0});
    if (base_raw > BASE_HI_LIMIT) begin
      base_adj = base_raw + GAP_HI;
    end else if (base_raw > BASE_LO_LIMIT) begin
      base_adj = base_raw + GAP_LO;
    end else begin
      base_adj = base_raw;
    end

    // Field start inside the 24-bit word whose top byte sits at the base index.
    start = 5'd21 - 5'({row_r4, 2'b00}) - 5'({row_r4, 1'b0}) - (odd ? 5'd0 : 5'd3);
    pos   = start + 5'(field_bit(odd, col));
    byte_idx = base_adj + CALC_W'(2) - CALC_W'(pos[4:3]);

    in_range = (pixel_x_i < 8'(WIDTH)) && (pixel_y_i < 5'(HEIGHT));

    cmd_o.pixel_on = pixel_on_i;
    cmd_o.bit_idx  = pos[2:0];
    if (op_i == OP_READ) begin
      cmd_o.kind = KIND_READ;
      addr_o     = ADDR_W'(read_address_i);
    end else if (in_range) begin
      cmd_o.kind = KIND_DRAW;
      addr_o     = ADDR_W'(byte_idx);
    end else begin
      cmd_o.kind = KIND_DROP;
      addr_o     = ADDR_W'(byte_idx);
    end
  end

endmodule

>>> rtl/vfdpw_fifo.sv
// Two-entry command queue between the front end and the back end.
module vfdpw_fifo #(
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/vfdpw_back.sv
// Back end: frame store memory, clearing pass, read-modify-write and result register.
module vfdpw_back #(
  parameter int unsigned STORE_BYTES = 1024,
  parameter int unsigned ADDR_W      = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  vfdpw_pkg::cmd_t    q_cmd_i,
  input  logic [ADDR_W-1:0]  q_addr_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic [1:0]         status_o
);
  import vfdpw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_MODIFY = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  cmd_t              cur_cmd_q;
  logic [ADDR_W-1:0] cur_addr_q;
  logic [7:0]        mem_q [STORE_BYTES];
  logic [7:0]        rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        bit_mask;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [7:0]        out_data_q;
  logic [1:0]        out_status_q;

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;
  assign bit_mask    = 8'b1 << cur_cmd_q.bit_idx;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr_q;
    mem_wdata = cur_cmd_q.pixel_on ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
    out_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'h00;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // Only start an item once the result register is sure to be free.
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          q_pop_o = 1'b1;
          state_d = S_MODIFY;
        end
      end
      S_MODIFY: begin
        mem_we   = (cur_cmd_q.kind == KIND_DRAW);
        out_load = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    out_valid_d = out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_cmd_q  <= q_cmd_i;
      cur_addr_q <= q_addr_i;
    end
    if (out_load) begin
      out_data_q   <= (cur_cmd_q.kind == KIND_READ) ? rdata_q : 8'h00;
      out_status_q <= (cur_cmd_q.kind == KIND_READ) ? ST_READ :
                      (cur_cmd_q.kind == KIND_DROP) ? ST_DROPPED : ST_WRITTEN;
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[q_addr_i];
  end

  a_modify_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MODIFY |=> out_valid_q)
    else $error("result register not loaded after a modify cycle");

  a_pop_needs_free_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!out_valid_q || out_ready_i))
    else $error("item started while the result register is held");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !q_pop_o)
    else $error("item started during the clearing pass");

  a_drop_never_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODIFY && cur_cmd_q.kind != KIND_DRAW) |-> !mem_we)
    else $error("frame store written for a dropped pixel or a read");

endmodule

>>> rtl/vfd_pixel_frame_writer.sv
// Top level of the VFD pixel frame writer: stream ports, front end, queue and back end.
//
// Usage:
//   The slave stream carries one item per transaction: a pixel draw (op = 0)
//   that sets or clears one dot in the packed frame store, or a byte read
//   (op = 1). Every item yields exactly one transaction on the master stream
//   with the read byte (zero for draws) and a status: written, dropped
//   (pixel outside WIDTH x HEIGHT) or read done.
//   The front end maps the pixel to a byte and bit in the same cycle it is
//   accepted and pushes it into a two-entry queue. The back end handles
//   each item in the read-modify-write of the frame store: in S_IDLE it pops
//   the item and issues the registered read, in S_MODIFY it writes the byte
//   back and loads the result register, so it takes no new item before it is
//   through with the last one.
//   After reset the back end clears the frame store one byte per cycle;
//   s_axis_tready_o stays low until that clearing pass is done.
//   When the receiver stalls, the result waits in the output register, the
//   back end holds, and the queue absorbs up to two more items before
//   s_axis_tready_o drops.
module vfd_pixel_frame_writer #(
  parameter int unsigned WIDTH       = 144,
  parameter int unsigned HEIGHT      = 20,
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // op[0], pixel_x[8:1], pixel_y[13:9], pixel_on[14], read_address[24:15]
  input  logic [vfdpw_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // read_data[7:0], status[9:8]
  output logic [vfdpw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import vfdpw_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned Q_W    = $bits(cmd_t) + ADDR_W;

  cmd_t              fe_cmd;
  logic [ADDR_W-1:0] fe_addr;
  logic              in_xfer;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [Q_W-1:0]    q_data;
  cmd_t              q_cmd;
  logic [ADDR_W-1:0] q_addr;
  logic              clearing;
  logic [7:0]        read_data;
  logic [1:0]        status;

  assign s_axis_tready_o = !q_full && !clearing;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign q_cmd           = q_data[$bits(cmd_t)-1:0];
  assign q_addr          = q_data[Q_W-1:$bits(cmd_t)];
  assign m_axis_tdata_o  = {6'b0, status, read_data};

  vfdpw_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .ADDR_W (ADDR_W)
  ) u_front (
    .op_i           (s_axis_tdata_i[0]),
    .pixel_x_i      (s_axis_tdata_i[8:1]),
    .pixel_y_i      (s_axis_tdata_i[13:9]),
    .pixel_on_i     (s_axis_tdata_i[14]),
    .read_address_i (s_axis_tdata_i[24:15]),
    .cmd_o          (fe_cmd),
    .addr_o         (fe_addr)
  );

  vfdpw_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i ({fe_addr, fe_cmd}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  vfdpw_back #(
    .STORE_BYTES (STORE_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_addr_i    (q_addr),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .read_data_o (read_data),
    .status_o    (status)
  );

endmodule
